FILE: src/ctf_pkg.sv
// Shared types, register indexes, decode constants and the channel map function.
`timescale 1ns / 1ps
`default_nettype none
package ctf_pkg;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 10;
  localparam logic [CFG_AW-1:0] REG_PRODUCT_CODE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FILTER_ON = 2'd1;
  localparam logic [CFG_AW-1:0] REG_STREAM_ON = 2'd2;

  localparam int unsigned PRODUCT_LSB = 19;
  localparam int unsigned MAX_RES = 4;

  localparam logic [2:0] TYPE_FIXED = 3'd0;
  localparam logic [2:0] TYPE_STREAM = 3'd2;
  localparam logic [11:0] FIXED_FIRST = 12'h600;
  localparam logic [11:0] FIXED_LAST = 12'h607;
  localparam logic [11:0] FIXED_GAP_A = 12'h604;
  localparam logic [11:0] FIXED_GAP_B = 12'h605;
  localparam logic [7:0] STREAM_MARK = 8'hFF;
  localparam logic [2:0] K_FUEL = 3'd7;
  localparam logic [2:0] K_ACCEL = 3'd6;
  localparam logic [4:0] BASE_FUEL = 5'd21;
  localparam logic [4:0] BASE_ACCEL = 5'd17;

  typedef struct packed {
    logic [4:0]  target;
    logic [15:0] pair_id;
    logic [15:0] value;
    logic        from_stream;
  } res_t;

  typedef struct packed {
    logic [2:0]           cnt;
    res_t [MAX_RES-1:0]   res;
  } bundle_t;

  function automatic logic [4:0] map_id(input logic [15:0] id);
    logic [4:0] t;
    unique case (id[15:1])
      15'h0001: t = 5'd1;
      15'h0002: t = 5'd2;
      15'h0003: t = 5'd3;
      15'h0004: t = 5'd4;
      15'h0005: t = 5'd5;
      15'h0006: t = 5'd6;
      15'h0007: t = 5'd7;
      15'h0011: t = 5'd8;
      15'h0027: t = 5'd9;
      15'h0042: t = 5'd10;
      15'h008C: t = 5'd11;
      15'h008D: t = 5'd12;
      15'h0150: t = 5'd22;
      default:  t = 5'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: src/ctf_front.sv
// Front end: filters and classifies frames, tracks segment state, builds result bundles.
`timescale 1ns / 1ps
`default_nettype none
module ctf_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [28:0]                   ext_id,
  input  wire logic                          is_extended,
  input  wire logic [3:0]                    frame_length,
  input  wire logic [63:0]                   payload,
  input  wire logic                          cfg_we,
  input  wire logic [ctf_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [ctf_pkg::CFG_DW-1:0]    cfg_wdata,
  output logic                               bnd_push,
  output ctf_pkg::bundle_t                   bnd
);
  import ctf_pkg::*;

  logic [9:0]  product_code_r;
  logic        filter_on_r;
  logic        stream_on_r;
  logic [15:0] pid_r, pid_nxt;
  logic [15:0] pval_r, pval_nxt;
  logic [7:0]  lseg_r, lseg_nxt;

  logic [3:0]  len_eff;
  logic [7:0]  b [8];
  logic        frame_ok;
  logic [2:0]  ftype;
  logic [11:0] low;
  logic        is_fixed, is_pair0, is_seg;
  logic        len8, len_ge6, len_ge7;
  logic [7:0]  seq;
  logic        match;
  logic        sp0_v, sp1_v;
  logic [15:0] sp0_id, sp0_val, sp1_id, sp1_val;
  logic        e0, e1;
  logic [2:0]  k;
  logic [4:0]  base;
  res_t        r0, r1;

  always_comb begin
    len_eff = (frame_length > 4'd8) ? 4'd8 : frame_length;
    for (int i = 0; i < 8; i++) begin
      b[i] = (4'(i) < len_eff) ? payload[63-8*i -: 8] : 8'h00;
    end
  end

  always_comb begin
    frame_ok = is_extended &&
               (!filter_on_r || (ext_id[PRODUCT_LSB +: 10] == product_code_r));
    ftype = ext_id[13:11];
    low = ext_id[11:0];
    is_fixed = frame_ok && (ftype == TYPE_FIXED) && (low >= FIXED_FIRST) &&
               (low <= FIXED_LAST) && (low != FIXED_GAP_A) && (low != FIXED_GAP_B);
    is_pair0 = frame_ok && (ftype == TYPE_FIXED) && !is_fixed &&
               (ext_id[7:0] == STREAM_MARK) && stream_on_r;
    is_seg = frame_ok && (ftype == TYPE_STREAM) && stream_on_r;
    len8 = (len_eff == 4'd8);
    len_ge6 = (len_eff >= 4'd6);
    len_ge7 = (len_eff >= 4'd7);
    seq = b[0];
    match = ({1'b0, seq} == ({1'b0, lseg_r} + 9'd1));
  end

  always_comb begin
    sp0_v = 1'b0;
    sp1_v = 1'b0;
    sp0_id = {b[0], b[1]};
    sp0_val = {b[2], b[3]};
    sp1_id = {b[4], b[5]};
    sp1_val = {b[6], b[7]};
    pid_nxt = pid_r;
    pval_nxt = pval_r;
    lseg_nxt = lseg_r;
    if (is_pair0) begin
      sp0_v = 1'b1;
      sp1_v = len8;
    end else if (is_seg) begin
      priority if (seq == STREAM_MARK) begin
        sp0_v = 1'b1;
        sp0_id = {b[1], b[2]};
        sp0_val = {b[3], b[4]};
      end else if (seq == 8'd0) begin
        sp0_v = 1'b1;
        sp0_id = {b[3], b[4]};
        sp0_val = {b[5], b[6]};
        lseg_nxt = seq;
      end else begin
        lseg_nxt = seq;
        unique case (seq[1:0])
          2'd1: begin
            sp0_v = match;
            sp0_id = pid_r | {8'h00, b[1]};
            sp0_val = {b[2], b[3]};
            sp1_v = len8;
          end
          2'd2: begin
            sp0_v = 1'b1;
            sp0_id = {b[1], b[2]};
            sp0_val = {b[3], b[4]};
          end
          2'd3: begin
            sp0_v = match;
            sp0_id = pid_r;
            sp0_val = pval_r | {8'h00, b[1]};
            sp1_v = len_ge6;
            sp1_id = {b[2], b[3]};
            sp1_val = {b[4], b[5]};
          end
          default: begin
            sp0_v = match;
            sp0_id = pid_r;
            sp0_val = {b[1], b[2]};
            sp1_v = len_ge7;
            sp1_id = {b[3], b[4]};
            sp1_val = {b[5], b[6]};
          end
        endcase
      end
    end
    if (sp1_v) begin
      pid_nxt = sp1_id;
      pval_nxt = sp1_val;
    end else if (sp0_v) begin
      pid_nxt = sp0_id;
      pval_nxt = sp0_val;
    end
    if (is_seg && (seq != STREAM_MARK)) begin
      if (seq == 8'd0) begin
        pid_nxt = {b[7], 8'h00};
      end else if (len8) begin
        unique case (seq[1:0])
          2'd1: ;
          2'd2: begin
            pid_nxt = {b[5], b[6]};
            pval_nxt = {b[7], 8'h00};
          end
          2'd3: pid_nxt = {b[6], b[7]};
          default: pid_nxt = {b[7], 8'h00};
        endcase
      end
    end
  end

  always_comb begin
    k = low[2:0];
    base = (k == K_FUEL) ? BASE_FUEL :
           (k == K_ACCEL) ? BASE_ACCEL : (5'({k, 2'b00}) + 5'd1);
    e0 = sp0_v && !sp0_id[0];
    e1 = sp1_v && !sp1_id[0];
    r0 = '{target: map_id(sp0_id), pair_id: sp0_id, value: sp0_val, from_stream: 1'b1};
    r1 = '{target: map_id(sp1_id), pair_id: sp1_id, value: sp1_val, from_stream: 1'b1};
    bnd = '0;
    if (is_fixed) begin
      bnd.cnt = (k == K_FUEL) ? 3'd2 : 3'd4;
      for (int i = 0; i < MAX_RES; i++) begin
        bnd.res[i].target = base + 5'(i);
        bnd.res[i].pair_id = 16'h0000;
        bnd.res[i].value = {b[2*i], b[2*i+1]};
        bnd.res[i].from_stream = 1'b0;
      end
    end else begin
      bnd.cnt = {1'b0, e0 & e1, e0 ^ e1};
      bnd.res[0] = e0 ? r0 : r1;
      bnd.res[1] = r1;
    end
    bnd_push = accept && (bnd.cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      product_code_r <= '0;
      filter_on_r <= 1'b1;
      stream_on_r <= 1'b1;
      pid_r <= '0;
      pval_r <= '0;
      lseg_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PRODUCT_CODE: product_code_r <= cfg_wdata[9:0];
          REG_FILTER_ON: filter_on_r <= cfg_wdata[0];
          REG_STREAM_ON: stream_on_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        pid_r <= pid_nxt;
        pval_r <= pval_nxt;
        lseg_r <= lseg_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/ctf_queue.sv
// Short queue of result bundles between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ctf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ctf_pkg::bundle_t  wdata,
  output logic                   full,
  output logic                   valid,
  input  wire logic              pop,
  output ctf_pkg::bundle_t       rdata
);
  import ctf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t        mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  always_comb begin
    full = (cnt_r == CW'(DEPTH));
    valid = (cnt_r != '0);
    rdata = mem_r[rptr_r];
    do_push = push && !full;
    do_pop = pop && valid;
    wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_nxt;
      end
      if (do_pop) begin
        rptr_r <= rptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/ctf_back.sv
// Output sequencer: sends the results of each bundle one beat at a time from a register.
`timescale 1ns / 1ps
`default_nettype none
module ctf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire ctf_pkg::bundle_t  q_head,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [4:0]             out_target,
  output logic [15:0]            out_pair_id,
  output logic [15:0]            out_value,
  output logic                   out_from_stream,
  output logic                   out_last
);
  import ctf_pkg::*;

  logic       ovalid_r;
  res_t       ores_r;
  logic       olast_r;
  logic [1:0] idx_r;
  logic       load, is_last;

  always_comb begin
    load = q_valid && (!ovalid_r || out_pop);
    is_last = (({1'b0, idx_r} + 3'd1) == q_head.cnt);
    q_pop = load && is_last;
    out_empty = !ovalid_r;
    out_target = ores_r.target;
    out_pair_id = ores_r.pair_id;
    out_value = ores_r.value;
    out_from_stream = ores_r.from_stream;
    out_last = olast_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ores_r <= q_head.res[idx_r];
      olast_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        ovalid_r <= 1'b1;
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_pop) begin
        ovalid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/can_telemetry_frame_decoder_top.sv
// Top level of the CAN telemetry frame decoder.
// A frame's first result is registered in the bundle queue and then in the output register before the ports.
// Throughput: a frame is taken every cycle while the bundle queue has room; the output
// register sends one result per cycle while out_pop is given, and a frame gives up to 4 results.
// Reset (synchronous, rst_n low) empties the queue and output register, zeroes the segment
// state and product code, and turns the product filter and stream decoding on.
`timescale 1ns / 1ps
`default_nettype none
module can_telemetry_frame_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [28:0]                  in_ext_id,
  input  wire logic                         in_is_extended,
  input  wire logic [3:0]                   in_frame_length,
  input  wire logic [63:0]                  in_payload,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [4:0]                        out_target,
  output logic [15:0]                       out_pair_id,
  output logic [15:0]                       out_value,
  output logic                              out_from_stream,
  output logic                              out_last,
  input  wire logic                         cfg_we,
  input  wire logic [ctf_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [ctf_pkg::CFG_DW-1:0]   cfg_wdata
);
  import ctf_pkg::*;

  logic    accept;
  logic    bnd_push;
  bundle_t bnd;
  logic    q_full, q_valid, q_pop;
  bundle_t q_head;

  assign in_full = q_full;
  assign accept = in_push && !q_full;

  ctf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .ext_id       (in_ext_id),
    .is_extended  (in_is_extended),
    .frame_length (in_frame_length),
    .payload      (in_payload),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .bnd_push     (bnd_push),
    .bnd          (bnd)
  );

  ctf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bnd_push),
    .wdata (bnd),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_head)
  );

  ctf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_target      (out_target),
    .out_pair_id     (out_pair_id),
    .out_value       (out_value),
    .out_from_stream (out_from_stream),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire
